// File: design/rcbhd_pkg.sv
// Shared types, constants and helper functions for the hop decoder core.
// No dependencies; imported by every module of the block.
package rcbhd_pkg;

  localparam int TIMER_BITS = 14;
  localparam int CFG_BITS   = 14;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_TO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_TO    = 2'd1;

  localparam logic [CFG_BITS-1:0] SEARCH_TO_RST = 14'd1000;
  localparam logic [CFG_BITS-1:0] RUN_TO_RST    = 14'd10000;

  // Operation codes of an input beat
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_PACKET = 1'b1;

  localparam logic [1:0]  BIND_BITS   = 2'b11;
  localparam logic [3:0]  HOP_IDX_RST = 4'd1;
  localparam logic [10:0] SWITCH_LO   = 11'd1000;
  localparam logic [10:0] SWITCH_HI   = 11'd2000;
  localparam logic [10:0] VALUE_BASE  = 11'd1000;
  localparam logic [7:0]  STICK_MID   = 8'h80;
  localparam logic [7:0]  STICK_FOLD  = 8'h7F;

  localparam logic [5:0] HOP_TABLE [4][16] = '{
    '{6'h27, 6'h1B, 6'h39, 6'h28, 6'h24, 6'h22, 6'h2E, 6'h36,
      6'h19, 6'h21, 6'h29, 6'h14, 6'h1E, 6'h12, 6'h2D, 6'h18},
    '{6'h2E, 6'h33, 6'h25, 6'h38, 6'h19, 6'h12, 6'h18, 6'h16,
      6'h2A, 6'h1C, 6'h1F, 6'h37, 6'h2F, 6'h23, 6'h34, 6'h10},
    '{6'h11, 6'h1A, 6'h35, 6'h24, 6'h28, 6'h18, 6'h25, 6'h2A,
      6'h32, 6'h2C, 6'h14, 6'h27, 6'h36, 6'h34, 6'h1C, 6'h17},
    '{6'h22, 6'h27, 6'h17, 6'h39, 6'h34, 6'h28, 6'h2B, 6'h1D,
      6'h18, 6'h2A, 6'h21, 6'h38, 6'h10, 6'h26, 6'h20, 6'h1F}
  };

  // Hop sequence position, passed from the control state to the channel select
  typedef struct packed {
    logic       bound;
    logic [1:0] row;
    logic [2:0] offset;
    logic [3:0] index;
  } hop_ctx_t;

  // Decoded frame values
  typedef struct packed {
    logic [10:0] throttle;
    logic [10:0] yaw;
    logic [10:0] pitch;
    logic [10:0] roll;
    logic [10:0] led;
    logic [10:0] flip;
    logic [10:0] camera;
    logic [10:0] video;
  } frame_t;

  // b*1000/255 + 1000; divide by 255 through a multiply by 257/65536 and one correction
  function automatic logic [10:0] scale_byte(input logic [7:0] b);
    logic [17:0] prod;
    logic [26:0] recip;
    logic [9:0]  quo;
    logic [17:0] rem;
    prod  = 18'(b) * 18'd1000;
    recip = 27'(prod) + (27'(prod) << 8);
    quo   = recip[25:16];
    rem   = prod - 18'(quo) * 18'd255;
    if (rem >= 18'd255) begin
      quo = quo + 10'd1;
    end
    return 11'(quo) + VALUE_BASE;
  endfunction

  // Sign-magnitude stick folded to an unsigned byte
  function automatic logic [7:0] fold_stick(input logic [7:0] a);
    return (a < STICK_MID) ? (STICK_FOLD - a) : a;
  endfunction

endpackage

// File: design/rc_link_bind_hop_decoder_core.sv
// Top level of the hop decoder: input register, link state, result register.
// Depends on rcbhd_pkg, rcbhd_hop_sel and rcbhd_frame_dec.

// Receiver control for a frequency-hopping RC link. Each input beat is either a
// one-microsecond tick or a received packet. The beat is captured in an input
// register. When the beat leaves that register, the link state (silence counter, hop
// position, bind data) is updated and any result is loaded into the output register
// that drives out_valid and the other result outputs. One beat is taken
// every clock cycle. The only limit is the result register: when it holds a beat
// that is stalled, a beat that produces a result waits, while ticks that do not hop
// keep flowing. A packet always yields one result beat (hop_now set, the next channel);
// a tick yields one only when the silence count passes the active timeout. The
// channel comes straight from a constant table, so no memory or clearing pass is
// involved. Configuration writes are always ready; write the two timeouts only
// while the block is idle. Writes to indexes other than 0 and 1 are ignored.
module rc_link_bind_hop_decoder_core
  import rcbhd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]  cfg_data,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_operation,
  input  logic [7:0]           in_throttle_byte,
  input  logic [7:0]           in_yaw_byte,
  input  logic [7:0]           in_pitch_byte,
  input  logic [7:0]           in_roll_byte,
  input  logic [7:0]           in_id_byte0,
  input  logic [7:0]           in_id_byte1,
  input  logic [7:0]           in_id_byte2,
  input  logic [7:0]           in_flags_byte,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_hop_now,
  output logic [5:0]           out_rf_channel,
  output logic                 out_frame_valid,
  output logic [10:0]          out_throttle_value,
  output logic [10:0]          out_yaw_value,
  output logic [10:0]          out_pitch_value,
  output logic [10:0]          out_roll_value,
  output logic [10:0]          out_aux_led,
  output logic [10:0]          out_aux_flip,
  output logic [10:0]          out_aux_camera,
  output logic [10:0]          out_aux_video,
  output logic                 out_is_bound
);

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

  // configuration
  logic [CFG_BITS-1:0]   search_to_r;
  logic [CFG_BITS-1:0]   run_to_r;

  // input register
  logic                  in_vld_r;
  logic                  op_r;
  logic [7:0]            thr_r, yaw_r, pitch_r, roll_r;
  logic [7:0]            id0_r, id1_r, id2_r, flags_r;

  // link state
  logic                  bound_r;
  logic [3:0]            hop_idx_r;
  logic [1:0]            hop_row_r;
  logic [2:0]            hop_off_r;
  logic [23:0]           id_r;
  logic                  long_to_r;
  logic [TIMER_BITS-1:0] sil_r;

  // result register
  logic                  out_vld_r;
  logic [5:0]            chan_r;
  logic                  frame_vld_r;
  frame_t                frame_r;
  logic                  bound_out_r;

  // combinational
  hop_ctx_t              hop_ctx;
  logic [5:0]            chan;
  frame_t                frame;
  logic [TIMER_BITS-1:0] cnt_inc;
  logic [TIMER_BITS-1:0] limit;
  logic                  hop_due;
  logic                  res_vld;
  logic                  out_free;
  logic                  adv;
  logic                  take_in;
  logic                  bind_pkt;
  logic                  bind_ok;
  logic                  frame_ok;
  logic [7:0]            id_sum;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_to_r <= SEARCH_TO_RST;
      run_to_r    <= RUN_TO_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SEARCH_TO: search_to_r <= cfg_data;
        CFG_RUN_TO:    run_to_r    <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Handshake: the input register frees when its beat is done with; a beat that
  // hops needs room in the result register.
  always_comb begin
    cnt_inc  = (sil_r < TIMER_MAX) ? (sil_r + 1'b1) : sil_r;
    limit    = long_to_r ? TIMER_BITS'(run_to_r) : TIMER_BITS'(search_to_r);
    hop_due  = (op_r == OP_TICK) && (cnt_inc > limit);
    res_vld  = (op_r == OP_PACKET) || hop_due;
    out_free = !out_vld_r || !out_stall;
    adv      = in_vld_r && (!res_vld || out_free);
    in_stall = in_vld_r && !adv;
    take_in  = in_valid && !in_stall;

    bind_pkt = (flags_r[7:6] == BIND_BITS);
    bind_ok  = (op_r == OP_PACKET) && !bound_r && bind_pkt;
    frame_ok = (op_r == OP_PACKET) && bound_r && !bind_pkt && ({id2_r, id1_r, id0_r} == id_r);
    id_sum   = id0_r + id1_r + id2_r;

    hop_ctx.bound  = bound_r;
    hop_ctx.row    = hop_row_r;
    hop_ctx.offset = hop_off_r;
    hop_ctx.index  = hop_idx_r;
  end

  rcbhd_hop_sel u_hop_sel (
    .ctx     (hop_ctx),
    .channel (chan)
  );

  rcbhd_frame_dec u_frame_dec (
    .throttle_byte (thr_r),
    .yaw_byte      (yaw_r),
    .pitch_byte    (pitch_r),
    .roll_byte     (roll_r),
    .flags_byte    (flags_r),
    .frame         (frame)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (take_in) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      op_r    <= in_operation;
      thr_r   <= in_throttle_byte;
      yaw_r   <= in_yaw_byte;
      pitch_r <= in_pitch_byte;
      roll_r  <= in_roll_byte;
      id0_r   <= in_id_byte0;
      id1_r   <= in_id_byte1;
      id2_r   <= in_id_byte2;
      flags_r <= in_flags_byte;
    end
  end

  // link state: advance once per beat leaving the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bound_r   <= 1'b0;
      hop_idx_r <= HOP_IDX_RST;
      hop_row_r <= '0;
      hop_off_r <= '0;
      id_r      <= '0;
      long_to_r <= 1'b0;
      sil_r     <= '0;
    end else if (adv) begin
      // restart the silence count on every packet and every hop
      sil_r <= res_vld ? '0 : cnt_inc;
      if (res_vld) begin
        hop_idx_r <= hop_idx_r + 4'd1;
      end
      if (bind_ok) begin
        bound_r   <= 1'b1;
        hop_row_r <= id_sum[1:0];
        hop_off_r <= id_sum[4:2];
        id_r      <= {id2_r, id1_r, id0_r};
        long_to_r <= 1'b0;
      end else if (frame_ok) begin
        long_to_r <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= adv && res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_vld) begin
      chan_r      <= chan;
      frame_vld_r <= frame_ok;
      // drop the frame values on anything that is not a valid frame
      frame_r     <= frame_ok ? frame : '0;
      bound_out_r <= bound_r || bind_ok;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_hop_now        = 1'b1;
  assign out_rf_channel     = chan_r;
  assign out_frame_valid    = frame_vld_r;
  assign out_throttle_value = frame_r.throttle;
  assign out_yaw_value      = frame_r.yaw;
  assign out_pitch_value    = frame_r.pitch;
  assign out_roll_value     = frame_r.roll;
  assign out_aux_led        = frame_r.led;
  assign out_aux_flip       = frame_r.flip;
  assign out_aux_camera     = frame_r.camera;
  assign out_aux_video      = frame_r.video;
  assign out_is_bound       = bound_out_r;

endmodule

// File: design/rcbhd_hop_sel.sv
// Next hop channel from the constant hop table and the current sequence position.
// Depends on rcbhd_pkg.
module rcbhd_hop_sel
  import rcbhd_pkg::*;
(
  input  hop_ctx_t   ctx,
  output logic [5:0] channel
);

  logic [6:0] raw;
  logic [6:0] shifted;

  always_comb begin
    raw     = 7'(HOP_TABLE[ctx.row][ctx.index]) + 7'(ctx.offset);
    // a channel on a multiple of sixteen moves down by three
    shifted = (raw[3:0] == 4'd0) ? (raw - 7'd3) : raw;
    if (ctx.bound) begin
      channel = shifted[5:0];
    end else begin
      channel = HOP_TABLE[0][ctx.index];
    end
  end

endmodule

// File: design/rcbhd_frame_dec.sv
// Scales the stick bytes and maps the switch flags of one data packet.
// Depends on rcbhd_pkg.
module rcbhd_frame_dec
  import rcbhd_pkg::*;
(
  input  logic [7:0] throttle_byte,
  input  logic [7:0] yaw_byte,
  input  logic [7:0] pitch_byte,
  input  logic [7:0] roll_byte,
  input  logic [7:0] flags_byte,
  output frame_t     frame
);

  always_comb begin
    frame.throttle = scale_byte(throttle_byte);
    frame.yaw      = scale_byte(fold_stick(yaw_byte));
    frame.pitch    = scale_byte(fold_stick(pitch_byte));
    frame.roll     = scale_byte(fold_stick(roll_byte));
    frame.led      = flags_byte[4] ? SWITCH_HI : SWITCH_LO;
    frame.flip     = flags_byte[2] ? SWITCH_HI : SWITCH_LO;
    frame.camera   = flags_byte[0] ? SWITCH_HI : SWITCH_LO;
    frame.video    = flags_byte[1] ? SWITCH_HI : SWITCH_LO;
  end

endmodule

// File: tb/sv/tb_top.sv
// Testbench for rc_link_bind_hop_decoder_core: sends tick and packet beats, predicts
// every hop, bind and decoded frame, and checks the result beats in order.
// Depends on rcbhd_pkg and the design sources under design/.
`timescale 1ns / 1ps

module tb_top;
  import rcbhd_pkg::*;

  // Indexes past the two timeout registers; the block must ignore writes to them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam logic [CFG_BITS-1:0]  TIMEOUT_MAX  = '1;

  localparam int DRAIN_CYCLES    = 4;      // wait after every owed result has arrived
  localparam int DRAIN_LIMIT     = 20000;
  localparam int BEATS_PER_RUN   = 325;    // input beats per random phase

  // Field order matters: the monitor packs port values straight into these
  typedef struct packed {
    logic        op;
    logic [7:0]  throttle;
    logic [7:0]  yaw;
    logic [7:0]  pitch;
    logic [7:0]  roll;
    logic [7:0]  flags;
    logic [23:0] tx_id;
  } beat_t;

  typedef struct packed {
    logic        hop_now;
    logic [5:0]  channel;
    logic        frame_valid;
    logic [10:0] throttle;
    logic [10:0] yaw;
    logic [10:0] pitch;
    logic [10:0] roll;
    logic [10:0] led;
    logic [10:0] flip;
    logic [10:0] camera;
    logic [10:0] video;
    logic        bound;
  } hop_result_t;

  // Link state of the receiver as seen from outside, plus the queue of hops
  // and frames still owed by the block.
  class hop_link_scoreboard;
    logic [CFG_BITS-1:0]   search_limit;
    logic [CFG_BITS-1:0]   run_limit;
    bit                    bound;
    bit                    run_limit_on;
    logic [3:0]            seq_pos;
    logic [1:0]            row;
    logic [2:0]            offset;
    logic [23:0]           own_id;
    logic [TIMER_BITS-1:0] quiet_us;
    hop_result_t           expected_hops[$];
    int                    beats;
    int                    predicted;
    int                    checked;
    int                    frames;
    int                    mismatches;

    function new();
      search_limit = SEARCH_TO_RST;
      run_limit    = RUN_TO_RST;
      bound        = 1'b0;
      run_limit_on = 1'b0;
      seq_pos      = HOP_IDX_RST;
      row          = '0;
      offset       = '0;
      own_id       = '0;
      quiet_us     = '0;
      beats        = 0;
      predicted    = 0;
      checked      = 0;
      frames       = 0;
      mismatches   = 0;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_BITS-1:0] value);
      case (idx)
        CFG_SEARCH_TO: search_limit = value;
        CFG_RUN_TO:    run_limit = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_hops.size();
    endfunction

    // Channel at the current position, then step the position
    function logic [5:0] advance_hop();
      logic [7:0] v;
      logic [5:0] ch;
      if (bound) begin
        v  = 8'(HOP_TABLE[row][seq_pos]) + 8'(offset);
        ch = (v[3:0] != 4'd0) ? v[5:0] : 6'(v - 8'd3);
      end else begin
        ch = HOP_TABLE[0][seq_pos];
      end
      seq_pos = seq_pos + 4'd1;
      return ch;
    endfunction

    function logic [10:0] scale_us(logic [7:0] b);
      return 11'(int'(b) * 1000 / 255) + VALUE_BASE;
    endfunction

    function logic [10:0] stick_us(logic [7:0] b);
      return scale_us((b < 8'h80) ? (8'h7F - b) : b);
    endfunction

    function logic [10:0] switch_us(logic bit_set);
      return bit_set ? SWITCH_HI : SWITCH_LO;
    endfunction

    function void note_beat(beat_t b);
      hop_result_t         r;
      logic [7:0]          id_sum;
      logic [CFG_BITS-1:0] limit;
      bit                  bind_req;
      r = '0;
      beats++;
      if (b.op == OP_TICK) begin
        limit = run_limit_on ? run_limit : search_limit;
        if (quiet_us != '1) quiet_us++;
        if (quiet_us <= limit) return;
        r.channel = advance_hop();
      end else begin
        r.channel = advance_hop();
        bind_req  = (b.flags[7:6] == BIND_BITS);
        if (!bound) begin
          if (bind_req) begin
            id_sum       = b.tx_id[7:0] + b.tx_id[15:8] + b.tx_id[23:16];
            row          = id_sum[1:0];
            offset       = id_sum[4:2];
            own_id       = b.tx_id;
            bound        = 1'b1;
            run_limit_on = 1'b0;
          end
        end else if (!bind_req && b.tx_id == own_id) begin
          run_limit_on  = 1'b1;
          frames++;
          r.frame_valid = 1'b1;
          r.throttle    = scale_us(b.throttle);
          r.yaw         = stick_us(b.yaw);
          r.pitch       = stick_us(b.pitch);
          r.roll        = stick_us(b.roll);
          r.led         = switch_us(b.flags[4]);
          r.flip        = switch_us(b.flags[2]);
          r.camera      = switch_us(b.flags[0]);
          r.video       = switch_us(b.flags[1]);
        end
      end
      quiet_us  = '0;
      r.hop_now = 1'b1;
      r.bound   = bound;
      expected_hops.push_back(r);
      predicted++;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got === want) return;
      mismatches++;
      if (mismatches <= 100) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(hop_result_t got);
      hop_result_t want;
      if (expected_hops.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing expected, expected none, got channel %0d",
                 $time, got.channel);
        return;
      end
      want = expected_hops.pop_front();
      checked++;
      compare_field("hop_now", want.hop_now, got.hop_now);
      compare_field("rf_channel", want.channel, got.channel);
      compare_field("frame_valid", want.frame_valid, got.frame_valid);
      compare_field("throttle_value", want.throttle, got.throttle);
      compare_field("yaw_value", want.yaw, got.yaw);
      compare_field("pitch_value", want.pitch, got.pitch);
      compare_field("roll_value", want.roll, got.roll);
      compare_field("aux_led", want.led, got.led);
      compare_field("aux_flip", want.flip, got.flip);
      compare_field("aux_camera", want.camera, got.camera);
      compare_field("aux_video", want.video, got.video);
      compare_field("is_bound", want.bound, got.bound);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0]  cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_operation = OP_TICK;
  logic [7:0]           in_throttle_byte = '0;
  logic [7:0]           in_yaw_byte = '0;
  logic [7:0]           in_pitch_byte = '0;
  logic [7:0]           in_roll_byte = '0;
  logic [7:0]           in_id_byte0 = '0;
  logic [7:0]           in_id_byte1 = '0;
  logic [7:0]           in_id_byte2 = '0;
  logic [7:0]           in_flags_byte = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_hop_now;
  logic [5:0]           out_rf_channel;
  logic                 out_frame_valid;
  logic [10:0]          out_throttle_value;
  logic [10:0]          out_yaw_value;
  logic [10:0]          out_pitch_value;
  logic [10:0]          out_roll_value;
  logic [10:0]          out_aux_led;
  logic [10:0]          out_aux_flip;
  logic [10:0]          out_aux_camera;
  logic [10:0]          out_aux_video;
  logic                 out_is_bound;

  hop_link_scoreboard sb;
  int                 send_idle_pct = 0;
  int                 stall_pct = 0;
  logic [23:0]        link_id = '0;   // transmitter ID the block bound to

  rc_link_bind_hop_decoder_core u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_throttle_byte   (in_throttle_byte),
    .in_yaw_byte        (in_yaw_byte),
    .in_pitch_byte      (in_pitch_byte),
    .in_roll_byte       (in_roll_byte),
    .in_id_byte0        (in_id_byte0),
    .in_id_byte1        (in_id_byte1),
    .in_id_byte2        (in_id_byte2),
    .in_flags_byte      (in_flags_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_hop_now        (out_hop_now),
    .out_rf_channel     (out_rf_channel),
    .out_frame_valid    (out_frame_valid),
    .out_throttle_value (out_throttle_value),
    .out_yaw_value      (out_yaw_value),
    .out_pitch_value    (out_pitch_value),
    .out_roll_value     (out_roll_value),
    .out_aux_led        (out_aux_led),
    .out_aux_flip       (out_aux_flip),
    .out_aux_camera     (out_aux_camera),
    .out_aux_video      (out_aux_video),
    .out_is_bound       (out_is_bound)
  );

  // 20 ns period
  always #10 clk = ~clk;

  // Receiver back-pressure: stall each cycle with the current probability
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watch both channels at the edge. Values read here are the ones from before
  // the edge, so the handshake seen is the one the block saw.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_beat(beat_t'({in_operation, in_throttle_byte, in_yaw_byte, in_pitch_byte,
                              in_roll_byte, in_flags_byte,
                              in_id_byte2, in_id_byte1, in_id_byte0}));
      end
      if (out_valid && !out_stall) begin
        sb.check_result(hop_result_t'({out_hop_now, out_rf_channel, out_frame_valid,
                                       out_throttle_value, out_yaw_value, out_pitch_value,
                                       out_roll_value, out_aux_led, out_aux_flip,
                                       out_aux_camera, out_aux_video, out_is_bound}));
      end
    end
  end

  // Present one beat and hold it until the block takes it. Idle cycles go in
  // front of the beat; valid stays high between back-to-back beats.
  task automatic send(beat_t b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= b.op;
    in_throttle_byte <= b.throttle;
    in_yaw_byte      <= b.yaw;
    in_pitch_byte    <= b.pitch;
    in_roll_byte     <= b.roll;
    in_flags_byte    <= b.flags;
    in_id_byte0      <= b.tx_id[7:0];
    in_id_byte1      <= b.tx_id[15:8];
    in_id_byte2      <= b.tx_id[23:16];
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
  endtask

  function automatic beat_t random_payload(logic op);
    beat_t b;
    b.op       = op;
    b.throttle = 8'($urandom);
    b.yaw      = 8'($urandom);
    b.pitch    = 8'($urandom);
    b.roll     = 8'($urandom);
    b.flags    = 8'($urandom);
    b.tx_id    = 24'($urandom);
    return b;
  endfunction

  // Packet from the bound transmitter with random sticks; drop one bind bit if
  // both came up set so the packet decodes as a frame
  function automatic beat_t frame_beat();
    beat_t b;
    b = random_payload(OP_PACKET);
    b.tx_id = link_id;
    if (b.flags[7:6] == BIND_BITS) b.flags[$urandom_range(7, 6)] = 1'b0;
    return b;
  endfunction

  task automatic tick_run(int count);
    repeat (count) send(random_payload(OP_TICK));
  endtask

  // Drop valid, wait for every owed result, then give the pipeline time to empty
  // of ticks that hop nowhere
  task automatic drain();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (sb.pending() != 0 && waited < DRAIN_LIMIT);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Hold a register write until the block takes it; valid stays high for the next
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    sb.apply_reg(idx, value);
  endtask

  // Idle the block, then load both timeouts and poke the unused indexes
  task automatic set_timeouts(logic [CFG_BITS-1:0] search_us, logic [CFG_BITS-1:0] run_us);
    drain();
    write_reg(CFG_SEARCH_TO, search_us);
    write_reg(CFG_RUN_TO, run_us);
    write_reg(CFG_SPARE_LO, CFG_BITS'($urandom));
    write_reg(CFG_SPARE_HI, CFG_BITS'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Mostly frames from the bound transmitter and bursts of ticks; the rest is
  // foreign IDs, IDs one bit off and bind attempts that a bound link rejects
  task automatic random_traffic(int beat_goal);
    beat_t b;
    int    pick;
    int    stop_at;
    stop_at = sb.beats + beat_goal;
    while (sb.beats < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        tick_run($urandom_range(1, 48));
      end else begin
        b = frame_beat();
        if (pick >= 94) begin
          b.flags[7:6] = BIND_BITS;
        end else if (pick >= 88) begin
          b.tx_id = b.tx_id ^ (24'd1 << $urandom_range(23, 0));
        end else if (pick >= 80) begin
          b.tx_id = 24'($urandom);
        end
        send(b);
      end
    end
  endtask

  initial begin
    beat_t      b;
    logic [1:0] row;
    logic [2:0] off;
    logic [7:0] id_sum;
    bit         wraps;
    sb = new();
    // First stretch: sender mostly busy, receiver mostly stalled
    send_idle_pct = 21;
    stall_pct     = 79;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Search timeout at its reset value: a short burst of ticks stays quiet
    tick_run(24);

    // Unbound packets: a single bind bit never binds; payload extremes
    send('{OP_PACKET, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h80, 24'hFFFFFF});
    send('{OP_PACKET, 8'h00, 8'h00, 8'h00, 8'h00, 8'h40, 24'h000000});
    send('{OP_PACKET, 8'h5A, 8'h7F, 8'h80, 8'hA5, 8'h3F, 24'h123456});

    // Zero search timeout: every tick hops
    drain();
    write_reg(CFG_SEARCH_TO, '0);
    cfg_valid <= 1'b0;
    tick_run(2);

    // Bind with an ID whose row and offset put a channel on a zero low nibble,
    // so the minus-three correction shows up in the bound sequence
    forever begin
      row   = 2'($urandom);
      off   = 3'($urandom);
      wraps = 1'b0;
      for (int k = 0; k < 16; k++) begin
        if ((8'(HOP_TABLE[row][k]) + 8'(off)) % 16 == 0) wraps = 1'b1;
      end
      if (wraps) break;
    end
    id_sum = {3'($urandom), off, row};
    b = random_payload(OP_PACKET);
    b.flags[7:6] = BIND_BITS;
    b.tx_id[23:16] = id_sum - b.tx_id[7:0] - b.tx_id[15:8];
    link_id = b.tx_id;
    send(b);
    // Bound hops on ticks, still under the short timeout
    tick_run(3);
    // Second bind from the same transmitter is rejected
    send(b);
    // Foreign transmitter
    b = frame_beat();
    b.tx_id = ~link_id;
    send(b);

    // Frames: stick folding around the midpoint, every switch, lone bind bits
    b = frame_beat();
    b.throttle = 8'h00;
    b.yaw      = 8'h00;
    b.pitch    = 8'h7F;
    b.roll     = 8'h80;
    b.flags    = 8'h00;
    send(b);
    b = frame_beat();
    b.throttle = 8'hFF;
    b.yaw      = 8'hFF;
    b.pitch    = 8'h80;
    b.roll     = 8'h7F;
    b.flags    = 8'h17;
    send(b);
    b = frame_beat();
    b.flags = 8'h80;
    send(b);
    b = frame_beat();
    b.flags = 8'h7F;
    send(b);

    // Run timeout at its reset value after a frame: a burst of ticks stays quiet
    tick_run(24);

    // Random traffic under short timeouts
    set_timeouts(CFG_BITS'($urandom_range(0, 40)), CFG_BITS'($urandom_range(1, 40)));
    random_traffic(BEATS_PER_RUN);

    // Second stretch: sender mostly idle, receiver mostly ready; run timeout zero
    send_idle_pct = 79;
    stall_pct     = 21;
    set_timeouts(TIMEOUT_MAX, '0);
    random_traffic(BEATS_PER_RUN);

    // Last stretch at full rate. Largest run timeout: a burst of ticks stays quiet
    send_idle_pct = 0;
    stall_pct     = 0;
    set_timeouts(CFG_BITS'($urandom_range(0, 40)), TIMEOUT_MAX);
    tick_run(40);
    send(frame_beat());
    set_timeouts('0, CFG_BITS'($urandom_range(2, 40)));
    random_traffic(BEATS_PER_RUN);

    drain();
    if (sb.pending() != 0) begin
      $display("%0d expected result beats never arrived", sb.pending());
    end
    $display("%0d beats sent, %0d result beats checked, %0d frames decoded",
             sb.beats, sb.checked, sb.frames);
    $display("unbound, bind, rejected and foreign packets; timeouts from zero to the largest");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule

// File: filelist.f
design/rcbhd_pkg.sv
design/rcbhd_hop_sel.sv
design/rcbhd_frame_dec.sv
design/rc_link_bind_hop_decoder_core.sv
tb/sv/tb_top.sv
